FILE: rtl/core/ps2mct_pkg.sv
// Shared constants for the PS/2 mouse packet cursor tracker.
`timescale 1ns / 1ps

package ps2mct_pkg;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_POSITION = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [CFG_DATA_BITS-1:0] RST_SCREEN_HEIGHT = 13'd768;

    // Controller status and packet bit positions
    localparam int STAT_READY_BIT = 0;
    localparam int STAT_AUX_BIT   = 5;
    localparam int SYNC_BIT       = 3;
    localparam int BUTTON_BITS    = 3;

    // Packet byte counter
    localparam logic [1:0] PKT_LAST = 2'd2;

endpackage

FILE: rtl/core/ps2_mouse_packet_cursor_tracker.sv
// Top level: PS/2 mouse three-byte packet decoder with clamped cursor tracking.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_status_byte, i_data_byte
//  out     | output    | o_out_valid / i_out_stall | o_cursor_x, o_cursor_y, o_buttons
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A transferred byte is held in the input register, then goes through the decode and clamp
//  logic into the output register. One byte is taken each cycle while the input does not stall.
//  Synchronous active-low reset clears the byte count, the cursor position and the
//  configuration to its defaults. The input stalls only while a result waits in the output
//  register and the output side stalls.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Byte input
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [7:0]                            i_status_byte,
    input  logic [7:0]                            i_data_byte,
    // Cursor output
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [COORD_BITS-1:0]                 o_cursor_x,
    output logic [COORD_BITS-1:0]                 o_cursor_y,
    output logic [ps2mct_pkg::BUTTON_BITS-1:0]    o_buttons,
    // Configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ps2mct_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ps2mct_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    // Working width: holds any extent, any coordinate plus a delta, and a sign bit.
    localparam int SW = ((COORD_BITS > ps2mct_pkg::CFG_DATA_BITS) ? COORD_BITS
                         : ps2mct_pkg::CFG_DATA_BITS) + 2;
    localparam logic [SW-1:0] COORD_MAX = {{(SW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

    // Configuration
    logic [ps2mct_pkg::CFG_DATA_BITS-1:0] r_screen_width;
    logic [ps2mct_pkg::CFG_DATA_BITS-1:0] r_screen_height;
    logic                                 r_hold_position;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_status;
    logic [7:0] r_data;

    // Packet state
    logic [1:0]            r_byte_count;
    logic [1:0]            n_byte_count;
    logic [7:0]            r_pkt_b0;
    logic [7:0]            r_pkt_b1;
    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;
    logic [COORD_BITS-1:0] n_pos_x;
    logic [COORD_BITS-1:0] n_pos_y;

    // Output register
    logic                               r_out_valid;
    logic [COORD_BITS-1:0]              r_cursor_x;
    logic [COORD_BITS-1:0]              r_cursor_y;
    logic [ps2mct_pkg::BUTTON_BITS-1:0] r_buttons;

    logic          advance;
    logic          byte_ok;
    logic          emit;
    logic          store_b0;
    logic          store_b1;
    logic [7:0]    dx;
    logic [7:0]    dy;
    logic [SW-1:0] sum_x;
    logic [SW-1:0] sum_y;
    logic [SW-1:0] hi_x;
    logic [SW-1:0] hi_y;

    function automatic logic [SW-1:0] upper_bound(
        input logic [ps2mct_pkg::CFG_DATA_BITS-1:0] extent
    );
        logic [SW-1:0] m;
        begin
            m = (extent == '0) ? '0 : SW'(extent) - SW'(1);
            upper_bound = (m > COORD_MAX) ? COORD_MAX : m;
        end
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic [SW-1:0] v,
        input logic [SW-1:0] hi
    );
        logic [SW-1:0] c;
        begin
            if (v[SW-1]) begin
                c = '0;
            end else if (v > hi) begin
                c = hi;
            end else begin
                c = v;
            end
            clamp_coord = c[COORD_BITS-1:0];
        end
    endfunction

    // The pipeline moves unless a result is parked in the output register.
    assign advance     = !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_cursor_x  = r_cursor_x;
    assign o_cursor_y  = r_cursor_y;
    assign o_buttons   = r_buttons;

    always_comb begin
        byte_ok  = r_in_valid && r_status[ps2mct_pkg::STAT_READY_BIT]
                   && r_status[ps2mct_pkg::STAT_AUX_BIT];
        store_b0 = 1'b0;
        store_b1 = 1'b0;
        emit     = 1'b0;
        n_byte_count = r_byte_count;

        if (byte_ok) begin
            if (r_byte_count != ps2mct_pkg::PKT_LAST) begin
                store_b0     = !r_byte_count[0];
                store_b1     = r_byte_count[0];
                n_byte_count = r_byte_count + 2'd1;
            end else begin
                n_byte_count = '0;
                emit         = r_pkt_b0[ps2mct_pkg::SYNC_BIT];
            end
        end

        dx = r_hold_position ? 8'd0 : r_pkt_b1;
        dy = r_hold_position ? 8'd0 : r_data;

        // X moves right with a positive delta; screen Y grows downward.
        sum_x = {{(SW-COORD_BITS){1'b0}}, r_pos_x} + {{(SW-8){dx[7]}}, dx};
        sum_y = {{(SW-COORD_BITS){1'b0}}, r_pos_y} - {{(SW-8){dy[7]}}, dy};
        hi_x  = upper_bound(r_screen_width);
        hi_y  = upper_bound(r_screen_height);

        n_pos_x = clamp_coord(sum_x, hi_x);
        n_pos_y = clamp_coord(sum_y, hi_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= ps2mct_pkg::RST_SCREEN_WIDTH;
            r_screen_height <= ps2mct_pkg::RST_SCREEN_HEIGHT;
            r_hold_position <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ps2mct_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                ps2mct_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                ps2mct_pkg::CFG_HOLD_POSITION: r_hold_position <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_status <= i_status_byte;
            r_data   <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_out_valid  <= 1'b0;
        end else if (advance) begin
            r_byte_count <= n_byte_count;
            r_out_valid  <= emit;
            if (emit) begin
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (store_b0) begin
                r_pkt_b0 <= r_data;
            end
            if (store_b1) begin
                r_pkt_b1 <= r_data;
            end
            if (emit) begin
                r_cursor_x <= n_pos_x;
                r_cursor_y <= n_pos_y;
                r_buttons  <= r_pkt_b0[ps2mct_pkg::BUTTON_BITS-1:0];
            end
        end
    end

endmodule

FILE: rtl/core/ps2mct_checker.sv
// Port-level checker for the PS/2 mouse packet cursor tracker, bound to the top level.
`timescale 1ns / 1ps

module ps2mct_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [COORD_BITS-1:0] o_cursor_x,
    input logic [COORD_BITS-1:0] o_cursor_y,
    input logic [2:0]            o_buttons
);

    // A stalled result holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_x)
            && $stable(o_cursor_y) && $stable(o_buttons))
    else $error("stalled result changed or dropped");

    // Reset leaves no result pending.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
    else $error("result valid after reset");

    // Input backpressure only comes from a parked result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
    else $error("input stalled without output backpressure");

    // A new result follows an earlier byte transfer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
    else $error("result appeared without a byte transfer");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mct_checker #(.COORD_BITS(COORD_BITS)) u_ps2mct_checker (.*);

FILE: sim/tb_ps2_mouse_packet_cursor_tracker.sv
// Self-checking testbench for the PS/2 mouse packet cursor tracker.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_cursor_tracker;

    localparam int COORD_BITS     = 12;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int IDLE_LIMIT     = 3000;
    localparam int PIPE_PAD       = 8;
    localparam int SQUEEZE_CYCLES = 150;

    // No register sits at this index; writes to it must be ignored.
    localparam logic [ps2mct_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0]              x;
        logic [COORD_BITS-1:0]              y;
        logic [ps2mct_pkg::BUTTON_BITS-1:0] btn;
    } t_cursor;

    class cursor_scoreboard;
        bit [ps2mct_pkg::CFG_DATA_BITS-1:0] width;
        bit [ps2mct_pkg::CFG_DATA_BITS-1:0] height;
        bit                                 hold;
        bit [1:0]                           nbytes;
        bit [7:0]                           pkt [2];
        int                                 px;
        int                                 py;
        t_cursor                            pending [$];
        int                                 errors;

        function new();
            width  = ps2mct_pkg::RST_SCREEN_WIDTH;
            height = ps2mct_pkg::RST_SCREEN_HEIGHT;
            hold   = 1'b0;
            nbytes = '0;
            pkt[0] = '0;
            pkt[1] = '0;
            px     = 0;
            py     = 0;
            errors = 0;
        endfunction

        // An extent of zero behaves as one; the top is capped by the coordinate width.
        function int clamp_axis(int v, bit [ps2mct_pkg::CFG_DATA_BITS-1:0] extent);
            int top;
            top = (extent == 0) ? 0 : int'(extent) - 1;
            if (top > COORD_MAX) top = COORD_MAX;
            if (v < 0) return 0;
            if (v > top) return top;
            return v;
        endfunction

        function void write_reg(bit [ps2mct_pkg::CFG_IDX_BITS-1:0] idx,
                                bit [ps2mct_pkg::CFG_DATA_BITS-1:0] val);
            case (idx)
                ps2mct_pkg::CFG_SCREEN_WIDTH:  width  = val;
                ps2mct_pkg::CFG_SCREEN_HEIGHT: height = val;
                ps2mct_pkg::CFG_HOLD_POSITION: hold   = val[0];
                default: ;
            endcase
        endfunction

        function void take_byte(bit [7:0] status, bit [7:0] data);
            int      nx;
            int      ny;
            t_cursor c;
            if (!status[ps2mct_pkg::STAT_READY_BIT] || !status[ps2mct_pkg::STAT_AUX_BIT])
                return;
            if (nbytes < ps2mct_pkg::PKT_LAST) begin
                pkt[nbytes[0]] = data;
                nbytes++;
                return;
            end
            nbytes = '0;
            if (!pkt[0][ps2mct_pkg::SYNC_BIT]) return;
            nx = px;
            ny = py;
            if (!hold) begin
                nx += int'($signed(pkt[1]));
                ny -= int'($signed(data));
            end
            px    = clamp_axis(nx, width);
            py    = clamp_axis(ny, height);
            c.x   = px[COORD_BITS-1:0];
            c.y   = py[COORD_BITS-1:0];
            c.btn = pkt[0][ps2mct_pkg::BUTTON_BITS-1:0];
            pending.push_back(c);
        endfunction

        function void check_cursor(t_cursor got);
            t_cursor want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d buttons=%0d",
                         $time, got.x, got.y, got.btn);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) begin
                $display("%0t: cursor_x expected %0d, got %0d", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: cursor_y expected %0d, got %0d", $time, want.y, got.y);
                errors++;
            end
            if (got.btn !== want.btn) begin
                $display("%0t: buttons expected %0d, got %0d", $time, want.btn, got.btn);
                errors++;
            end
        endfunction
    endclass

    logic                                 i_clk         = 1'b0;
    logic                                 i_rst_n       = 1'b0;
    logic                                 i_in_valid    = 1'b0;
    logic [7:0]                           i_status_byte = '0;
    logic [7:0]                           i_data_byte   = '0;
    logic                                 i_out_stall   = 1'b0;
    logic                                 i_cfg_valid   = 1'b0;
    logic [ps2mct_pkg::CFG_IDX_BITS-1:0]  i_cfg_index   = '0;
    logic [ps2mct_pkg::CFG_DATA_BITS-1:0] i_cfg_data    = '0;
    logic                                 o_in_stall;
    logic                                 o_out_valid;
    logic [COORD_BITS-1:0]                o_cursor_x;
    logic [COORD_BITS-1:0]                o_cursor_y;
    logic [ps2mct_pkg::BUTTON_BITS-1:0]   o_buttons;
    logic                                 o_cfg_ready;

    cursor_scoreboard sb;
    int               idle_cycles = 0;
    bit               squeeze_req = 1'b0;
    bit               squeeze_on  = 1'b0;

    ps2_mouse_packet_cursor_tracker #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_status_byte(i_status_byte),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cursor_x   (o_cursor_x),
        .o_cursor_y   (o_cursor_y),
        .o_buttons    (o_buttons),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Results are checked before the same edge's input transfer is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_cursor('{x: o_cursor_x, y: o_cursor_y, btn: o_buttons});
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                sb.take_byte(i_status_byte, i_data_byte);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output back-pressure: quiet stretches, random stalls, long holds and one squeeze.
    initial begin
        int span;
        int mode;
        forever begin
            if (squeeze_req) begin
                i_out_stall <= 1'b1;
                squeeze_on = 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
                squeeze_req = 1'b0;
                squeeze_on  = 1'b0;
            end else begin
                mode = $urandom_range(0, 9);
                span = (mode == 9) ? $urandom_range(20, 60) : $urandom_range(1, 24);
                for (int k = 0; k < span; k++) begin
                    if (mode < 4)
                        i_out_stall <= 1'b0;
                    else if (mode < 8)
                        i_out_stall <= ($urandom_range(0, 2) == 0);
                    else if (mode == 8)
                        i_out_stall <= ($urandom_range(0, 3) != 0);
                    else
                        i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
        end
    end

    function automatic int next_gap(bit tight);
        int r;
        r = $urandom_range(0, 99);
        if (tight || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [7:0] live_status();
        logic [7:0] s;
        s = 8'($urandom_range(0, 255));
        s[ps2mct_pkg::STAT_READY_BIT] = 1'b1;
        s[ps2mct_pkg::STAT_AUX_BIT]   = 1'b1;
        return s;
    endfunction

    // Deltas are extremes, biased toward one side, or plain random.
    function automatic logic [7:0] pick_delta(int dir);
        logic [7:0] v;
        int         r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            case ($urandom_range(0, 4))
                0:       v = 8'h7F;
                1:       v = 8'h80;
                2:       v = 8'h00;
                3:       v = 8'hFF;
                default: v = 8'h01;
            endcase
        end else if (r < 9 && dir != 0) begin
            v = 8'($urandom_range(64, 127));
            if (dir < 0) v = -v;
        end else begin
            v = 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    // Holds valid across back-to-back transfers; lowers it only when a gap follows.
    task automatic send_byte(input logic [7:0] status, input logic [7:0] data, input int gap);
        i_in_valid    <= 1'b1;
        i_status_byte <= status;
        i_data_byte   <= data;
        do @(posedge i_clk); while (o_in_stall);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [ps2mct_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [ps2mct_pkg::CFG_DATA_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every predicted cursor has arrived, then let dropped packets drain.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_PAD) @(posedge i_clk);
    endtask

    task automatic configure(input logic [ps2mct_pkg::CFG_DATA_BITS-1:0] w,
                             input logic [ps2mct_pkg::CFG_DATA_BITS-1:0] h,
                             input logic hold);
        settle();
        write_reg(ps2mct_pkg::CFG_SCREEN_WIDTH, w);
        write_reg(ps2mct_pkg::CFG_SCREEN_HEIGHT, h);
        write_reg(ps2mct_pkg::CFG_HOLD_POSITION,
                  {{(ps2mct_pkg::CFG_DATA_BITS - 1){1'b0}}, hold});
    endtask

    // Mostly well-formed packets, with ignored bytes, stray bytes and bad sync mixed in.
    task automatic run_phase(input int n, input bit tight, input int dir_x, input int dir_y);
        int         sent;
        int         r;
        logic [7:0] head;
        logic [7:0] s;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                s = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 2))
                    0:       s[ps2mct_pkg::STAT_READY_BIT] = 1'b0;
                    1:       s[ps2mct_pkg::STAT_AUX_BIT]   = 1'b0;
                    default: s = s & ~(8'h1 << ps2mct_pkg::STAT_READY_BIT)
                                   & ~(8'h1 << ps2mct_pkg::STAT_AUX_BIT);
                endcase
                send_byte(s, 8'($urandom_range(0, 255)), next_gap(tight));
            end else if (r < 12) begin
                send_byte(live_status(), 8'($urandom_range(0, 255)), next_gap(tight));
                sent++;
            end else begin
                head = 8'($urandom_range(0, 255));
                if (r < 90) head[ps2mct_pkg::SYNC_BIT] = 1'b1;
                send_byte(live_status(), head, next_gap(tight));
                send_byte(live_status(), pick_delta(dir_x), next_gap(tight));
                send_byte(live_status(), pick_delta(dir_y), next_gap(tight));
                sent += 3;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bytes without both ready and auxiliary flags are skipped.
        send_byte(8'h00, 8'hFF, 1);
        send_byte(8'h01, 8'hFF, 0);
        send_byte(8'h20, 8'h00, 0);
        send_byte(8'hDE, 8'hAA, 2);
        // All buttons, largest positive X and largest downward Y.
        send_byte(8'h21, 8'h0F, 0);
        send_byte(8'hFF, 8'h7F, 0);
        send_byte(8'h21, 8'h80, 1);
        // A skipped byte inside a packet; X runs below zero.
        send_byte(8'h21, 8'h08, 0);
        send_byte(8'h1F, 8'h55, 0);
        send_byte(8'h21, 8'h80, 0);
        send_byte(8'h21, 8'h7F, 0);
        // Sync bit clear: the packet is dropped.
        send_byte(8'h21, 8'hF7, 0);
        send_byte(8'h21, 8'h01, 0);
        send_byte(8'h21, 8'h01, 0);
        send_byte(8'h21, 8'hFA, 0);
        send_byte(8'h21, 8'hFF, 0);
        send_byte(8'h21, 8'h00, 3);

        configure(13'd1, 13'd1, 1'b0);
        run_phase(30, 1'b0, 0, 0);

        configure(13'd0, 13'd0, 1'b0);
        write_reg(CFG_UNUSED, 13'h1FFF);
        run_phase(30, 1'b1, 0, 0);

        // Drive the cursor far enough to hit the coordinate ceiling.
        configure(13'h1FFF, 13'h1FFF, 1'b0);
        run_phase(150, 1'b0, 1, -1);

        configure(13'd4096, 13'd4096, 1'b1);
        run_phase(30, 1'b0, 0, 0);

        // Shrinking the screen pulls the cursor in; the output side holds off meanwhile.
        configure(13'd700, 13'd500, 1'b0);
        squeeze_req = 1'b1;
        wait (squeeze_on);
        run_phase(60, 1'b1, 0, 0);

        configure(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), 1'b0);
        run_phase(60, 1'b0, -1, 1);

        configure(13'd100, 13'd50, 1'b1);
        run_phase(20, 1'b0, 1, 1);

        configure(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), 1'b0);
        run_phase(40, 1'b0, 0, 0);

        settle();
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ps2mct_pkg.sv
rtl/core/ps2_mouse_packet_cursor_tracker.sv
rtl/core/ps2mct_checker.sv
sim/tb_ps2_mouse_packet_cursor_tracker.sv
